[rtl/complex_arith_unit_macros.svh]
// assertion macros for the complex arithmetic unit
// used by complex_arith_unit.sv, which supplies clk and rst_n in its scope
`ifndef COMPLEX_ARITH_UNIT_MACROS_SVH
`define COMPLEX_ARITH_UNIT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define CAU_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define CAU_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/cau_pkg.sv]
// shared types, constants and helper functions for the complex arithmetic unit
// no dependencies; used by cau_iter_pipe and complex_arith_unit
`default_nettype none

package cau_pkg;

    localparam int DIV_STEPS    = 48;
    localparam int SQRT_STEPS   = 24;
    localparam int CORDIC_STEPS = 24;

    // quarter turn in units of 2^-24 rad
    localparam logic signed [27:0] HALF_PI = 28'sd26353589;

    // atan(2^-i) in units of 2^-24 rad
    localparam logic signed [27:0] ATAN_TAB [CORDIC_STEPS] = '{
        28'sd13176795, 28'sd7778716, 28'sd4110060, 28'sd2086331,
        28'sd1047214,  28'sd524117,  28'sd262123,  28'sd131069,
        28'sd65536,    28'sd32768,   28'sd16384,   28'sd8192,
        28'sd4096,     28'sd2048,    28'sd1024,    28'sd512,
        28'sd256,      28'sd128,     28'sd64,      28'sd32,
        28'sd16,       28'sd8,       28'sd4,       28'sd2
    };

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_MUL = 3'd1,
        OP_DIV = 3'd2,
        OP_MAG = 3'd3,
        OP_ARG = 3'd4
    } op_t;

    // payload of one iteration stage
    typedef struct packed {
        op_t                func;
        logic               dz;
        logic               neg_re;
        logic               neg_im;
        logic        [31:0] dir_re;
        logic        [31:0] dir_im;
        logic               dir_sat;
        logic        [31:0] den;
        logic        [31:0] rem_re;
        logic        [31:0] rem_im;
        logic        [47:0] dq_re;
        logic        [47:0] dq_im;
        logic        [47:0] sq_x;
        logic        [25:0] sq_rem;
        logic        [23:0] sq_root;
        logic signed [39:0] cx;
        logic signed [39:0] cy;
        logic signed [27:0] cz;
    } iter_t;

    // clip a 33-bit signed value to 32 bits, flag in the top bit
    function automatic logic [32:0] sat33(logic [32:0] v);
        logic [32:0] res;
        if (v[32] != v[31])
            res = {1'b1, (v[32] ? 32'h8000_0000 : 32'h7FFF_FFFF)};
        else
            res = {1'b0, v[31:0]};
        return res;
    endfunction

    // apply sign to a quotient magnitude and clip, flag in the top bit
    function automatic logic [32:0] div_sat(logic [47:0] q, logic neg);
        logic [32:0] res;
        logic        ovf;
        if (neg) begin
            ovf = (|q[47:32]) || (q[31] && (|q[30:0]));
            res = ovf ? {1'b1, 32'h8000_0000} : {1'b0, 32'd0 - q[31:0]};
        end
        else begin
            ovf = |q[47:31];
            res = ovf ? {1'b1, 32'h7FFF_FFFF} : {1'b0, q[31:0]};
        end
        return res;
    endfunction

endpackage

`default_nettype wire

[rtl/complex_arith_unit.sv]
// complex arithmetic unit: a result passes stages a, b and c, the iteration stages
// and the final stage; any hold of the pipe, skid register wait included, delays it
// throughput one per cycle while not held; depth set by the 48-step restoring divider
// root and cordic ride in the same stages
// rst_n clears every valid bit and the skid flag at once; payload registers are not reset
// depends on cau_pkg, cau_iter_pipe and complex_arith_unit_macros.svh
`default_nettype none

`include "complex_arith_unit_macros.svh"

module complex_arith_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,   // a_real, a_imag, b_real, b_imag
    input  wire logic [2:0]  s_axis_tuser,   // func
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [63:0]      m_axis_tdata,   // res_real, res_imag
    output logic [1:0]       m_axis_tuser    // saturated, div_zero
);

    // ------------------------------------------------------------------
    // input skid register: catches one transaction while the pipe is held
    // ------------------------------------------------------------------
    logic        skid_v_reg;
    logic        skid_v_next;
    logic [63:0] skid_data_reg;
    logic [2:0]  skid_user_reg;

    logic        ce;         // whole pipe advances
    logic        in_fire;
    logic        feed_v;
    logic [63:0] feed_data;
    logic [2:0]  feed_user;

    logic out_v_reg;

    assign ce            = !out_v_reg || m_axis_tready;
    assign s_axis_tready = !skid_v_reg;
    assign in_fire       = s_axis_tvalid && !skid_v_reg;
    assign feed_v        = skid_v_reg || in_fire;
    assign feed_data     = skid_v_reg ? skid_data_reg : s_axis_tdata;
    assign feed_user     = skid_v_reg ? skid_user_reg : s_axis_tuser;

    always_comb
    begin
        skid_v_next = skid_v_reg;
        if (ce)
            skid_v_next = 1'b0;
        else if (in_fire)
            skid_v_next = 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (!ce && in_fire)
        begin
            skid_data_reg <= s_axis_tdata;
            skid_user_reg <= s_axis_tuser;
        end
    end

    // ------------------------------------------------------------------
    // stage a: the eight 16x16 products, the two sums and the cordic quarter-turn
    // ------------------------------------------------------------------
    logic signed [15:0] f_ar;
    logic signed [15:0] f_ai;
    logic signed [15:0] f_br;
    logic signed [15:0] f_bi;

    assign f_ar = feed_data[15:0];
    assign f_ai = feed_data[31:16];
    assign f_br = feed_data[47:32];
    assign f_bi = feed_data[63:48];

    logic               a_v_reg;
    cau_pkg::op_t       a_func_reg;
    logic signed [31:0] a_p_rr_reg, a_p_ii_reg, a_p_ri_reg, a_p_ir_reg;
    logic signed [31:0] a_p_bbr_reg, a_p_bbi_reg, a_p_aar_reg, a_p_aai_reg;
    logic signed [16:0] a_sum_re_reg, a_sum_im_reg;
    logic signed [39:0] a_cx_reg, a_cy_reg;
    logic signed [27:0] a_cz_reg;
    logic               a_azero_reg;

    logic signed [39:0] a_cx_next, a_cy_next;
    logic signed [27:0] a_cz_next;
    logic signed [39:0] x0, y0;

    always_comb
    begin
        x0 = {{4{f_ar[15]}}, f_ar, 20'd0};
        y0 = {{4{f_ai[15]}}, f_ai, 20'd0};
        if (f_ar[15])
        begin
            // left half plane: turn by a quarter so the vectoring converges
            if (!f_ai[15])
            begin
                a_cx_next = y0;
                a_cy_next = -x0;
                a_cz_next = cau_pkg::HALF_PI;
            end
            else
            begin
                a_cx_next = -y0;
                a_cy_next = x0;
                a_cz_next = -cau_pkg::HALF_PI;
            end
        end
        else
        begin
            a_cx_next = x0;
            a_cy_next = y0;
            a_cz_next = 28'sd0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            a_func_reg   <= cau_pkg::op_t'(feed_user);
            a_p_rr_reg   <= 32'(f_ar) * 32'(f_br);
            a_p_ii_reg   <= 32'(f_ai) * 32'(f_bi);
            a_p_ri_reg   <= 32'(f_ar) * 32'(f_bi);
            a_p_ir_reg   <= 32'(f_ai) * 32'(f_br);
            a_p_bbr_reg  <= 32'(f_br) * 32'(f_br);
            a_p_bbi_reg  <= 32'(f_bi) * 32'(f_bi);
            a_p_aar_reg  <= 32'(f_ar) * 32'(f_ar);
            a_p_aai_reg  <= 32'(f_ai) * 32'(f_ai);
            a_sum_re_reg <= 17'(f_ar) + 17'(f_br);
            a_sum_im_reg <= 17'(f_ai) + 17'(f_bi);
            a_cx_reg     <= a_cx_next;
            a_cy_reg     <= a_cy_next;
            a_cz_reg     <= a_cz_next;
            a_azero_reg  <= (f_ar == 16'sd0) && (f_ai == 16'sd0);
        end
    end

    // ------------------------------------------------------------------
    // stage b: numerators, squared magnitudes, add and multiply results
    // ------------------------------------------------------------------
    logic               b_v_reg;
    cau_pkg::op_t       b_func_reg;
    logic signed [32:0] b_num_re_reg, b_num_im_reg;
    logic        [31:0] b_den_reg, b_msq_reg;
    logic        [31:0] b_dir_re_reg, b_dir_im_reg;
    logic               b_dir_sat_reg;
    logic signed [39:0] b_cx_reg, b_cy_reg;
    logic signed [27:0] b_cz_reg;
    logic               b_azero_reg;

    logic signed [32:0] mul_re, mul_im;
    logic        [32:0] mul_re_sat, mul_im_sat;
    logic        [31:0] b_dir_re_next, b_dir_im_next;
    logic               b_dir_sat_next;

    always_comb
    begin
        mul_re     = 33'(a_p_rr_reg) - 33'(a_p_ii_reg);
        mul_im     = 33'(a_p_ri_reg) + 33'(a_p_ir_reg);
        mul_re_sat = cau_pkg::sat33(mul_re);
        mul_im_sat = cau_pkg::sat33(mul_im);
        case (a_func_reg)
            cau_pkg::OP_ADD:
            begin
                // q8.8 sum moved up to q15.16, never clips
                b_dir_re_next  = {{7{a_sum_re_reg[16]}}, a_sum_re_reg, 8'd0};
                b_dir_im_next  = {{7{a_sum_im_reg[16]}}, a_sum_im_reg, 8'd0};
                b_dir_sat_next = 1'b0;
            end
            cau_pkg::OP_MUL:
            begin
                b_dir_re_next  = mul_re_sat[31:0];
                b_dir_im_next  = mul_im_sat[31:0];
                b_dir_sat_next = mul_re_sat[32] || mul_im_sat[32];
            end
            default:
            begin
                b_dir_re_next  = 32'd0;
                b_dir_im_next  = 32'd0;
                b_dir_sat_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            b_func_reg    <= a_func_reg;
            b_num_re_reg  <= 33'(a_p_rr_reg) + 33'(a_p_ii_reg);
            b_num_im_reg  <= 33'(a_p_ir_reg) - 33'(a_p_ri_reg);
            b_den_reg     <= $unsigned(a_p_bbr_reg) + $unsigned(a_p_bbi_reg);
            b_msq_reg     <= $unsigned(a_p_aar_reg) + $unsigned(a_p_aai_reg);
            b_dir_re_reg  <= b_dir_re_next;
            b_dir_im_reg  <= b_dir_im_next;
            b_dir_sat_reg <= b_dir_sat_next;
            b_cx_reg      <= a_cx_reg;
            b_cy_reg      <= a_cy_reg;
            b_cz_reg      <= a_cz_reg;
            b_azero_reg   <= a_azero_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage c: rounded dividends (|num| * 2^16 + den/2) and radicand
    // ------------------------------------------------------------------
    logic           c_v_reg;
    cau_pkg::iter_t c_reg;
    cau_pkg::iter_t c_next;
    logic [31:0]    den_half;
    logic [48:0]    nsh_re, nsh_im;
    logic [48:0]    dvd_re, dvd_im;

    always_comb
    begin
        den_half = {1'b0, b_den_reg[31:1]};
        nsh_re   = {b_num_re_reg, 16'd0};
        nsh_im   = {b_num_im_reg, 16'd0};
        // a negative numerator is folded in by subtracting instead of negating
        dvd_re   = b_num_re_reg[32] ? ({17'd0, den_half} - nsh_re)
                                    : (nsh_re + {17'd0, den_half});
        dvd_im   = b_num_im_reg[32] ? ({17'd0, den_half} - nsh_im)
                                    : (nsh_im + {17'd0, den_half});

        c_next         = '0;
        c_next.func    = b_func_reg;
        c_next.dz      = ((b_func_reg == cau_pkg::OP_DIV) && (b_den_reg == 32'd0))
                      || ((b_func_reg == cau_pkg::OP_ARG) && b_azero_reg);
        c_next.neg_re  = b_num_re_reg[32];
        c_next.neg_im  = b_num_im_reg[32];
        c_next.dir_re  = b_dir_re_reg;
        c_next.dir_im  = b_dir_im_reg;
        c_next.dir_sat = b_dir_sat_reg;
        c_next.den     = b_den_reg;
        c_next.dq_re   = dvd_re[47:0];
        c_next.dq_im   = dvd_im[47:0];
        c_next.sq_x    = {b_msq_reg, 16'd0};
        c_next.cx      = b_cx_reg;
        c_next.cy      = b_cy_reg;
        c_next.cz      = b_cz_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            c_reg <= c_next;
        end
    end

    // ------------------------------------------------------------------
    // 48 iteration stages
    // ------------------------------------------------------------------
    logic           it_v;
    cau_pkg::iter_t it_data;

    cau_iter_pipe u_iter (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (c_v_reg),
        .in_data   (c_reg),
        .out_valid (it_v),
        .out_data  (it_data)
    );

    // ------------------------------------------------------------------
    // final stage: sign, rounding, clipping and result select
    // ------------------------------------------------------------------
    logic [63:0] out_data_reg;
    logic [1:0]  out_user_reg;
    logic [31:0] res_re, res_im;
    logic        res_sat;
    logic [32:0] q_re_sat, q_im_sat;
    logic [27:0] z_rnd;

    always_comb
    begin
        q_re_sat = cau_pkg::div_sat(it_data.dq_re, it_data.neg_re);
        q_im_sat = cau_pkg::div_sat(it_data.dq_im, it_data.neg_im);
        z_rnd    = it_data.cz + 28'sd128;
        res_re   = 32'd0;
        res_im   = 32'd0;
        res_sat  = 1'b0;
        case (it_data.func)
            cau_pkg::OP_ADD,
            cau_pkg::OP_MUL:
            begin
                res_re  = it_data.dir_re;
                res_im  = it_data.dir_im;
                res_sat = it_data.dir_sat;
            end
            cau_pkg::OP_DIV:
            begin
                if (!it_data.dz)
                begin
                    res_re  = q_re_sat[31:0];
                    res_im  = q_im_sat[31:0];
                    res_sat = q_re_sat[32] || q_im_sat[32];
                end
            end
            cau_pkg::OP_MAG:
            begin
                // round to nearest: bump when the remainder exceeds the root
                res_re = {8'd0, it_data.sq_root}
                       + {31'd0, (it_data.sq_rem > {2'b00, it_data.sq_root})};
            end
            cau_pkg::OP_ARG:
            begin
                if (!it_data.dz)
                    res_re = {{12{z_rnd[27]}}, z_rnd[27:8]};
            end
            default:
            begin
                res_re  = 32'd0;
                res_im  = 32'd0;
                res_sat = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            out_data_reg <= {res_im, res_re};
            out_user_reg <= {it_data.dz, res_sat};
        end
    end

    // ------------------------------------------------------------------
    // valid bits and skid flag
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_v_reg <= 1'b0;
            a_v_reg    <= 1'b0;
            b_v_reg    <= 1'b0;
            c_v_reg    <= 1'b0;
            out_v_reg  <= 1'b0;
        end
        else
        begin
            skid_v_reg <= skid_v_next;
            if (ce)
            begin
                a_v_reg   <= feed_v;
                b_v_reg   <= a_v_reg;
                c_v_reg   <= b_v_reg;
                out_v_reg <= it_v;
            end
        end
    end

    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `CAU_ASSERT_IMP(a_flags_excl, m_axis_tvalid, !(m_axis_tuser[0] && m_axis_tuser[1]), "saturated and div_zero both set")
    `CAU_ASSERT_IMP(a_dz_zero, m_axis_tvalid && m_axis_tuser[1], m_axis_tdata == 64'd0, "div_zero transaction with non-zero result")
    `CAU_ASSERT_IMP(a_skid_load, $rose(skid_v_reg), $past(s_axis_tvalid && !ce), "skid register filled without a held input transaction")

endmodule

`default_nettype wire

[rtl/cau_iter_pipe.sv]
// iteration pipeline: restoring divide, square root and cordic, one step per stage
// depends on cau_pkg
`default_nettype none

module cau_iter_pipe (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          ce,
    input  wire logic          in_valid,
    input  wire cau_pkg::iter_t in_data,
    output logic               out_valid,
    output cau_pkg::iter_t     out_data
);

    logic [cau_pkg::DIV_STEPS-1:0] vld_reg;
    cau_pkg::iter_t                pipe_reg  [cau_pkg::DIV_STEPS];
    cau_pkg::iter_t                step_next [cau_pkg::DIV_STEPS];

    for (genvar k = 0; k < cau_pkg::DIV_STEPS; k++) begin : g_step
        cau_pkg::iter_t     src;
        cau_pkg::iter_t     nxt;
        logic        [32:0] sh_re;
        logic        [32:0] sh_im;
        logic        [32:0] df_re;
        logic        [32:0] df_im;
        logic               ge_re;
        logic               ge_im;
        logic        [25:0] sq_rem_n;
        logic        [23:0] sq_root_n;
        logic signed [39:0] cx_n;
        logic signed [39:0] cy_n;
        logic signed [27:0] cz_n;

        if (k == 0) begin : g_first
            assign src = in_data;
        end
        else begin : g_rest
            assign src = pipe_reg[k-1];
        end

        // one quotient bit for each part
        always_comb
        begin
            sh_re = {src.rem_re, src.dq_re[47]};
            sh_im = {src.rem_im, src.dq_im[47]};
            df_re = sh_re - {1'b0, src.den};
            df_im = sh_im - {1'b0, src.den};
            ge_re = sh_re >= {1'b0, src.den};
            ge_im = sh_im >= {1'b0, src.den};
        end

        if (k < cau_pkg::SQRT_STEPS) begin : g_sq
            logic [27:0] acc;
            logic [27:0] trial;
            logic [27:0] sdiff;

            // one root bit per stage
            always_comb
            begin
                acc   = {src.sq_rem, src.sq_x[47:46]};
                trial = {2'b00, src.sq_root, 2'b01};
                sdiff = acc - trial;
                if (acc >= trial)
                begin
                    sq_rem_n  = sdiff[25:0];
                    sq_root_n = {src.sq_root[22:0], 1'b1};
                end
                else
                begin
                    sq_rem_n  = acc[25:0];
                    sq_root_n = {src.sq_root[22:0], 1'b0};
                end
            end
        end
        else begin : g_sq_hold
            assign sq_rem_n  = src.sq_rem;
            assign sq_root_n = src.sq_root;
        end

        if (k < cau_pkg::CORDIC_STEPS) begin : g_cordic
            logic signed [39:0] xs;
            logic signed [39:0] ys;
            logic signed [27:0] zs;
            logic signed [39:0] dx;
            logic signed [39:0] dy;

            // vectoring step, drives y towards zero
            always_comb
            begin
                xs = src.cx;
                ys = src.cy;
                zs = src.cz;
                dx = ys >>> k;
                dy = xs >>> k;
                if (ys > 40'sd0)
                begin
                    cx_n = xs + dx;
                    cy_n = ys - dy;
                    cz_n = zs + cau_pkg::ATAN_TAB[k];
                end
                else
                begin
                    cx_n = xs - dx;
                    cy_n = ys + dy;
                    cz_n = zs - cau_pkg::ATAN_TAB[k];
                end
            end
        end
        else begin : g_cordic_hold
            assign cx_n = src.cx;
            assign cy_n = src.cy;
            assign cz_n = src.cz;
        end

        always_comb
        begin
            nxt         = src;
            nxt.rem_re  = ge_re ? df_re[31:0] : sh_re[31:0];
            nxt.rem_im  = ge_im ? df_im[31:0] : sh_im[31:0];
            nxt.dq_re   = {src.dq_re[46:0], ge_re};
            nxt.dq_im   = {src.dq_im[46:0], ge_im};
            nxt.sq_x    = {src.sq_x[45:0], 2'b00};
            nxt.sq_rem  = sq_rem_n;
            nxt.sq_root = sq_root_n;
            nxt.cx      = cx_n;
            nxt.cy      = cy_n;
            nxt.cz      = cz_n;
        end

        assign step_next[k] = nxt;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (ce)
        begin
            vld_reg <= {vld_reg[cau_pkg::DIV_STEPS-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            for (int i = 0; i < cau_pkg::DIV_STEPS; i++)
            begin
                pipe_reg[i] <= step_next[i];
            end
        end
    end

    assign out_valid = vld_reg[cau_pkg::DIV_STEPS-1];
    assign out_data  = pipe_reg[cau_pkg::DIV_STEPS-1];

endmodule

`default_nettype wire
